FILE: design/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg - shared types and constants for the sorted list engine
// Request and result transfer formats, operation codes and the command
// broadcast from the controller to every list cell.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int KEY_W      = 32;
  localparam int COUNT_W    = 5;
  localparam int FUNC_W     = 3;
  localparam int CAPACITY_D = 16;

  localparam logic [FUNC_W-1:0] OP_INS_HEAD = 3'd0;
  localparam logic [FUNC_W-1:0] OP_INS_TAIL = 3'd1;
  localparam logic [FUNC_W-1:0] OP_INS_SORT = 3'd2;
  localparam logic [FUNC_W-1:0] OP_RM_HEAD  = 3'd3;
  localparam logic [FUNC_W-1:0] OP_RM_TAIL  = 3'd4;
  localparam logic [FUNC_W-1:0] OP_RM_KEY   = 3'd5;
  localparam logic [FUNC_W-1:0] OP_QUERY    = 3'd6;

  typedef struct packed {
    logic [FUNC_W-1:0]      func;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic                    ok;
    logic signed [KEY_W-1:0] key_out;
    logic [COUNT_W-1:0]      count;
  } out_item_t;

  // controller to cell broadcast
  typedef struct packed {
    logic                    cmp_en;   // compare phase: latch per-cell flags
    logic                    upd_ins;  // update phase, insert that fits
    logic                    upd_rm;   // update phase, removal
    logic [FUNC_W-1:0]       func;
    logic signed [KEY_W-1:0] key;
  } cell_cmd_t;

endpackage

FILE: design/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell - one list position
// Holds one key, flags itself against the request in the compare phase and
// shifts left or right, or takes the new key, in the update phase.
// ----------------------------------------------------------------------------
module sle_cell import sle_pkg::*; #(
  parameter int CAPACITY = CAPACITY_D,
  parameter int IDX      = 0,
  parameter int FILL_W   = $clog2(CAPACITY + 1)
) (
  input  logic                    clk,
  input  cell_cmd_t               cmd,
  input  logic [FILL_W-1:0]       fill,
  input  logic signed [KEY_W-1:0] left_key,
  input  logic signed [KEY_W-1:0] right_key,
  input  logic                    seen_in,
  output logic                    seen_out,
  output logic signed [KEY_W-1:0] entry,
  output logic signed [KEY_W-1:0] sel_key
);

  localparam logic [FILL_W-1:0] IDX_V  = FILL_W'(IDX);
  localparam logic [FILL_W-1:0] IDX_V1 = FILL_W'(IDX + 1);

  logic signed [KEY_W-1:0] entry_r, entry_nxt;
  logic                    hit_r, hit_nxt;
  logic                    at_fill_r, at_fill_nxt;
  logic                    occ;

  assign occ = (IDX_V < fill);

  always_comb begin
    unique case (cmd.func)
      OP_INS_HEAD: hit_nxt = (IDX == 0);
      OP_INS_TAIL: hit_nxt = 1'b0;
      OP_INS_SORT: hit_nxt = occ && (entry_r >= cmd.key);
      OP_RM_HEAD:  hit_nxt = occ && (IDX == 0);
      OP_RM_TAIL:  hit_nxt = occ && (IDX_V1 == fill);
      OP_RM_KEY,
      OP_QUERY:    hit_nxt = occ && (entry_r == cmd.key);
      default:     hit_nxt = 1'b0;
    endcase
    at_fill_nxt = (IDX_V == fill);
  end

  // priority chain: seen_in is high when a cell nearer the head was flagged
  assign seen_out = seen_in | hit_r;
  assign sel_key  = (hit_r && !seen_in) ? entry_r : '0;
  assign entry    = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.upd_ins) begin
      if (seen_in) entry_nxt = left_key;
      else if (hit_r || at_fill_r) entry_nxt = cmd.key;
    end else if (cmd.upd_rm && seen_out) begin
      entry_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (cmd.cmp_en) begin
      hit_r     <= hit_nxt;
      at_fill_r <= at_fill_nxt;
    end
  end

endmodule

FILE: design/sorted_list_engine_unit.sv
// ----------------------------------------------------------------------------
// sorted_list_engine_unit - bounded ordered list of signed keys
// A request is registered, the cells latch their flags in the compare phase,
// then the priority chain and shift phase run through the cell row with the
// result register in the update phase, which waits while the output stalls.
// A new request is taken only when idle or as the previous one completes.
// Reset clears the fill count and control; stored keys stay undefined.
// ----------------------------------------------------------------------------
module sorted_list_engine_unit import sle_pkg::*; #(
  parameter int CAPACITY = CAPACITY_D
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int FILL_W = $clog2(CAPACITY + 1);
  localparam logic [FILL_W-1:0] CAP_V = FILL_W'(CAPACITY);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  in_item_t          req_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic              upd_go, accept, is_ins, is_rm, full, any_hit;
  cell_cmd_t         cmd;
  logic                    seen   [CAPACITY+1];
  logic signed [KEY_W-1:0] ent    [CAPACITY];
  logic signed [KEY_W-1:0] selk   [CAPACITY];
  logic signed [KEY_W-1:0] kout;

  assign is_ins  = (req_r.func == OP_INS_HEAD) || (req_r.func == OP_INS_TAIL) ||
                   (req_r.func == OP_INS_SORT);
  assign is_rm   = (req_r.func == OP_RM_HEAD) || (req_r.func == OP_RM_TAIL) ||
                   (req_r.func == OP_RM_KEY);
  assign full    = (fill_r == CAP_V);
  assign upd_go  = (state_r == ST_UPD) && (!out_valid_r || !out_stall);
  assign in_stall = !((state_r == ST_IDLE) || upd_go);
  assign accept  = in_valid && !in_stall;

  assign cmd.cmp_en  = (state_r == ST_CMP);
  assign cmd.upd_ins = upd_go && is_ins && !full;
  assign cmd.upd_rm  = upd_go && is_rm;
  assign cmd.func    = req_r.func;
  assign cmd.key     = req_r.key;

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_W-1:0] lk, rk;
    if (i == 0) begin : g_l0
      assign lk = '0;
    end else begin : g_ln
      assign lk = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_rl
      assign rk = '0;
    end else begin : g_rn
      assign rk = ent[i+1];
    end
    sle_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i),
      .FILL_W   (FILL_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .fill      (fill_r),
      .left_key  (lk),
      .right_key (rk),
      .seen_in   (seen[i]),
      .seen_out  (seen[i+1]),
      .entry     (ent[i]),
      .sel_key   (selk[i])
    );
  end

  assign any_hit = seen[CAPACITY];

  // at most one cell drives a non-zero selected key
  always_comb begin
    kout = '0;
    for (int i = 0; i < CAPACITY; i++) kout = kout | selk[i];
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.upd_ins) fill_nxt = fill_r + FILL_W'(1);
    else if (cmd.upd_rm && any_hit) fill_nxt = fill_r - FILL_W'(1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD:  if (upd_go) state_nxt = accept ? ST_CMP : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      if (upd_go) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) req_r <= in_data;
    if (upd_go) begin
      out_r.ok      <= is_ins ? !full : ((is_rm || req_r.func == OP_QUERY) && any_hit);
      out_r.key_out <= is_rm ? kout : '0;
      out_r.count   <= COUNT_W'(fill_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: test/tb_sorted_list_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_sorted_list_engine_unit - self-checking bench for the sorted list engine
// Drives list requests (head/tail/sorted inserts, head/tail/key removals,
// membership queries and the unused code) through the valid/stall channel.
// A shadow copy of the list predicts each answer, which is compared field by
// field against the answers transferred out. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_sorted_list_engine_unit;
  import sle_pkg::*;

  localparam logic [FUNC_W-1:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_REQS = 850;
  localparam int QUIET_FROM  = 700;   // no idling on either side past this
  localparam int CYCLE_LIMIT = 200000;

  // shadow list and queue of answers still owed by the block
  class list_scoreboard;
    logic signed [KEY_W-1:0] shadow_list[$];
    out_item_t               answers_due[$];
    int                      mismatches;
    int                      answers_seen;

    function new();
      mismatches   = 0;
      answers_seen = 0;
    endfunction

    task flag_mismatch(string what, longint got, longint want);
      $display("answer %0d: %s got %0d, want %0d", answers_seen, what, got, want);
      mismatches++;
    endtask

    function void note_request(in_item_t req);
      out_item_t               ans;
      logic signed [KEY_W-1:0] k;
      int                      pos;
      k   = req.key;
      pos = 0;
      ans = '0;
      case (req.func)
        OP_INS_HEAD, OP_INS_TAIL, OP_INS_SORT: begin
          if (shadow_list.size() < CAPACITY_D) begin
            if (req.func == OP_INS_TAIL) begin
              pos = shadow_list.size();
            end else if (req.func == OP_INS_SORT) begin
              // goes in front of the first entry not below the key
              while (pos < shadow_list.size() && shadow_list[pos] < k) pos++;
            end
            shadow_list.insert(pos, k);
            ans.ok = 1'b1;
          end
        end
        OP_RM_HEAD: begin
          if (shadow_list.size() > 0) begin
            ans.key_out = shadow_list.pop_front();
            ans.ok      = 1'b1;
          end
        end
        OP_RM_TAIL: begin
          if (shadow_list.size() > 0) begin
            ans.key_out = shadow_list.pop_back();
            ans.ok      = 1'b1;
          end
        end
        OP_RM_KEY, OP_QUERY: begin
          pos = -1;
          foreach (shadow_list[i]) begin
            if (pos < 0 && shadow_list[i] == k) pos = i;
          end
          if (pos >= 0) begin
            ans.ok = 1'b1;
            if (req.func == OP_RM_KEY) begin
              ans.key_out = shadow_list[pos];
              shadow_list.delete(pos);
            end
          end
        end
        default: ;
      endcase
      ans.count = COUNT_W'(shadow_list.size());
      answers_due.push_back(ans);
    endfunction

    task check_answer(out_item_t got);
      out_item_t want;
      if (answers_due.size() == 0) begin
        flag_mismatch("unrequested answer, count", got.count, -1);
      end else begin
        want = answers_due.pop_front();
        if (got.ok !== want.ok) flag_mismatch("ok", got.ok, want.ok);
        if (got.key_out !== want.key_out)
          flag_mismatch("key_out", $signed(got.key_out), $signed(want.key_out));
        if (got.count !== want.count) flag_mismatch("count", got.count, want.count);
      end
      answers_seen++;
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  list_scoreboard sb;
  int  reqs_sent;
  int  cycle_count;
  int  rx_pause_left;
  bit  tx_idle_en;
  bit  rx_idle_en;

  sorted_list_engine_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // transfers are taken at the rising edge on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (out_valid && !out_stall) sb.check_answer(out_data);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sorted_list_engine_unit regression: fail");
      $finish;
    end
  end

  // receiver back-pressure in bursts
  always @(negedge clk) begin
    if (rx_pause_left > 0) begin
      out_stall     <= 1'b1;
      rx_pause_left <= rx_pause_left - 1;
    end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
      out_stall     <= 1'b1;
      rx_pause_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_req(input logic [FUNC_W-1:0] f, input logic signed [KEY_W-1:0] k);
    in_item_t req;
    req.func = f;
    req.key  = k;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (f != OP_UNUSED) reqs_sent++;
  endtask

  task automatic drain_answers();
    in_valid <= 1'b0;
    while (sb.answers_due.size() != 0) @(negedge clk);
  endtask

  // key source: full range, a narrow band for duplicates, extremes, or held keys
  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return int'($urandom_range(0, 16)) - 8;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return '0;
          default: return '1;
        endcase
      end
      default: begin
        if (sb.shadow_list.size() == 0) return $urandom();
        return sb.shadow_list[$urandom_range(0, sb.shadow_list.size() - 1)];
      end
    endcase
  endfunction

  initial begin
    int seg_kind;
    int seg_len;
    logic [FUNC_W-1:0] f;
    sb            = new();
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    reqs_sent     = 0;
    cycle_count   = 0;
    rx_pause_left = 0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list: every removal fails, query absent, unused code inert
    send_req(OP_RM_HEAD, 32'sd5);
    send_req(OP_RM_TAIL, 32'sd5);
    send_req(OP_RM_KEY, 32'sd0);
    send_req(OP_QUERY, 32'sd0);
    send_req(OP_UNUSED, 32'sd3);
    // extremes at both ends, sorted inserts including an equal key
    send_req(OP_INS_HEAD, 32'sh7FFF_FFFF);
    send_req(OP_INS_TAIL, 32'sh8000_0000);
    send_req(OP_INS_SORT, 32'sd0);
    send_req(OP_INS_SORT, -32'sd1);
    send_req(OP_INS_SORT, 32'sd0);
    send_req(OP_QUERY, 32'sd0);
    send_req(OP_QUERY, 32'sd5);
    send_req(OP_RM_KEY, 32'sd5);
    send_req(OP_RM_KEY, 32'sd0);
    send_req(OP_RM_HEAD, '0);
    send_req(OP_RM_TAIL, '0);
    send_req(OP_UNUSED, 32'sh8000_0000);
    send_req(OP_RM_HEAD, '0);
    // single entry left: tail removal hands back that key
    send_req(OP_RM_TAIL, '0);
    send_req(OP_RM_TAIL, '0);
    drain_answers();

    reqs_sent = 0;
    while (reqs_sent < RANDOM_REQS) begin
      if (reqs_sent >= QUIET_FROM) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end else begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 7) == 0) drain_answers();
      end
      seg_kind = $urandom_range(0, 3);
      seg_len  = (seg_kind == 3) ? $urandom_range(10, 30) : $urandom_range(14, 20);
      repeat (seg_len) begin
        case (seg_kind)
          0: f = FUNC_W'($urandom_range(0, 2));              // fill past full
          1: f = FUNC_W'($urandom_range(3, 5));              // drain past empty
          2: f = ($urandom_range(0, 1) != 0) ? OP_INS_SORT : OP_RM_KEY;
          default: f = FUNC_W'($urandom_range(0, 7));        // anything, noise
        endcase
        send_req(f, pick_key());
      end
    end

    in_valid <= 1'b0;
    while (sb.answers_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("sorted_list_engine_unit regression: pass");
    end else begin
      $display("sorted_list_engine_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: sorted_list_engine_unit.f
design/sle_pkg.sv
design/sle_cell.sv
design/sorted_list_engine_unit.sv
test/tb_sorted_list_engine_unit.sv
